### src/assert_macros.svh
// Assertion macros shared by the RTL that carries assertions.
// No dependencies; pulled in by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property under clock and async reset.
`define DRD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define DRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### src/drd_pkg.sv
// Types and constants of the dual range direction detector.
// No dependencies; used by the interfaces and every module.
package drd_pkg;

    localparam int DIST_W  = 12;
    localparam int CODE_W  = 2;
    localparam int WGT_W   = 16;
    localparam int AVG_W   = 28;
    localparam int FRAC_W  = 16;
    localparam int SEEN_W  = 2;
    localparam int EV_W    = 2;
    localparam int IDX_W   = 2;

    localparam logic [CODE_W-1:0] RC_VALID = 2'd0;
    localparam logic [CODE_W-1:0] RC_WEAK  = 2'd1;
    localparam logic [CODE_W-1:0] RC_ERROR = 2'd2;

    localparam logic [DIST_W-1:0] WEAK_VALUE  = 12'd1300;
    localparam logic [DIST_W-1:0] ERROR_VALUE = 12'd1301;

    localparam logic [SEEN_W-1:0] SEEN_NONE = 2'd0;
    localparam logic [SEEN_W-1:0] SEEN_A    = 2'd1;
    localparam logic [SEEN_W-1:0] SEEN_B    = 2'd2;
    localparam logic [SEEN_W-1:0] SEEN_BOTH = 2'd3;

    localparam logic [EV_W-1:0] EV_NONE = 2'd0;
    localparam logic [EV_W-1:0] EV_IN   = 2'd1;
    localparam logic [EV_W-1:0] EV_OUT  = 2'd2;

    localparam logic [IDX_W-1:0] CFG_ZONE_LOW  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_ZONE_HIGH = 2'd1;
    localparam logic [IDX_W-1:0] CFG_WEIGHT    = 2'd2;

    typedef struct packed {
        logic [DIST_W-1:0] raw_dist_a;
        logic [CODE_W-1:0] read_code_a;
        logic [DIST_W-1:0] raw_dist_b;
        logic [CODE_W-1:0] read_code_b;
    } in_beat_t;

    typedef struct packed {
        logic [DIST_W-1:0] range_a;
        logic [DIST_W-1:0] range_b;
        logic [SEEN_W-1:0] zone_seen;
        logic [EV_W-1:0]   pass_event;
    } out_beat_t;

    // Filtered or substituted distances handed from front to back.
    typedef struct packed {
        logic [DIST_W-1:0] d_a;
        logic [DIST_W-1:0] d_b;
    } item_t;

    typedef struct packed {
        logic [DIST_W-1:0] zone_low;
        logic [DIST_W-1:0] zone_high;
        logic [WGT_W-1:0]  smooth_weight;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### src/drd_intf.sv
// Handshake channel interfaces: sensor beats, result beats, config writes.
// Depends on drd_pkg.
interface drd_in_if;
    logic               valid;
    logic               ready;
    drd_pkg::in_beat_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface drd_out_if;
    logic               valid;
    logic               ready;
    drd_pkg::out_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface drd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [drd_pkg::IDX_W-1:0]     idx;
    logic [drd_pkg::WGT_W-1:0]     wdata;
    modport source (output valid, output idx, output wdata, input ready);
    modport sink   (input valid, input idx, input wdata, output ready);
endinterface

### src/drd_front.sv
// Front end: glitch filter and status substitution for both sensors.
// Depends on drd_pkg; feeds drd_fifo.
module drd_front #(
    parameter int GLITCH_LIMIT = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  drd_pkg::in_beat_t beat,
    output drd_pkg::item_t    item
);

    localparam logic [drd_pkg::DIST_W-1:0] LIMIT = drd_pkg::DIST_W'(GLITCH_LIMIT);

    logic [drd_pkg::DIST_W-1:0] mid_a_reg, old_a_reg, mid_b_reg, old_b_reg;
    logic [drd_pkg::DIST_W-1:0] mid_a_next, old_a_next, mid_b_next, old_b_next;

    function automatic logic [drd_pkg::DIST_W-1:0] adiff(
        input logic [drd_pkg::DIST_W-1:0] x,
        input logic [drd_pkg::DIST_W-1:0] y
    );
        adiff = (x > y) ? x - y : y - x;
    endfunction

    // glitch: middle sample stands apart from an otherwise steady pair
    function automatic logic glitch(
        input logic [drd_pkg::DIST_W-1:0] smp,
        input logic [drd_pkg::DIST_W-1:0] mid,
        input logic [drd_pkg::DIST_W-1:0] old
    );
        glitch = (adiff(old, smp) < LIMIT) && (adiff(mid, old) > LIMIT);
    endfunction

    function automatic logic [drd_pkg::DIST_W-1:0] subst(
        input logic [drd_pkg::CODE_W-1:0] code,
        input logic [drd_pkg::DIST_W-1:0] old
    );
        logic [drd_pkg::DIST_W-1:0] v;
        case (code)
            drd_pkg::RC_VALID: v = old;
            drd_pkg::RC_WEAK:  v = drd_pkg::WEAK_VALUE;
            default:           v = drd_pkg::ERROR_VALUE;
        endcase
        subst = v;
    endfunction

    always_comb
    begin
        item.d_a   = subst(beat.read_code_a, old_a_reg);
        item.d_b   = subst(beat.read_code_b, old_b_reg);
        mid_a_next = mid_a_reg;
        old_a_next = old_a_reg;
        mid_b_next = mid_b_reg;
        old_b_next = old_b_reg;
        if (accept && beat.read_code_a == drd_pkg::RC_VALID)
        begin
            old_a_next = glitch(beat.raw_dist_a, mid_a_reg, old_a_reg) ? old_a_reg : mid_a_reg;
            mid_a_next = beat.raw_dist_a;
        end
        if (accept && beat.read_code_b == drd_pkg::RC_VALID)
        begin
            old_b_next = glitch(beat.raw_dist_b, mid_b_reg, old_b_reg) ? old_b_reg : mid_b_reg;
            mid_b_next = beat.raw_dist_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_a_reg <= '0;
            old_a_reg <= '0;
            mid_b_reg <= '0;
            old_b_reg <= '0;
        end
        else
        begin
            mid_a_reg <= mid_a_next;
            old_a_reg <= old_a_next;
            mid_b_reg <= mid_b_next;
            old_b_reg <= old_b_next;
        end
    end

endmodule

### src/drd_fifo.sv
// Short queue decoupling front and back ends.
// Depends on drd_pkg.
module drd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  drd_pkg::item_t      wr_item,
    input  logic                pop,
    output drd_pkg::item_t      rd_item,
    output drd_pkg::q_status_t  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    drd_pkg::item_t     mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign status.full  = (cnt_reg == FULL_CNT);
    assign status.empty = (cnt_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign rd_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### src/drd_back.sv
// Back end: exponential smoothing, zone compare, passage matching, output reg.
// Depends on drd_pkg; drains drd_fifo.
module drd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  drd_pkg::cfg_t       cfg,
    input  logic                q_empty,
    input  drd_pkg::item_t      q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output drd_pkg::out_beat_t  out_beat
);

    localparam int DW = drd_pkg::DIST_W;
    localparam int AW = drd_pkg::AVG_W;
    localparam int WW = drd_pkg::WGT_W;
    localparam int FW = drd_pkg::FRAC_W;
    localparam int SW = drd_pkg::SEEN_W;

    logic                   adv;
    logic [WW:0]            keep_c;
    logic [AW-1:0]          avg_a_reg, avg_b_reg, avg_a_next, avg_b_next;
    logic                   s1_valid_reg, out_valid_reg;
    logic [DW-1:0]          s1_ra_reg, s1_rb_reg;
    logic [SW-1:0]          prior_reg, prior_next;
    logic [SW-1:0]          hist_reg [4];
    logic [SW-1:0]          hist_next [4];
    logic [SW-1:0]          seen;
    logic [drd_pkg::EV_W-1:0] ev;
    drd_pkg::out_beat_t     out_reg;

    // new = floor(avg*w / 2^16) + d*(2^16 - w); the d term is already whole
    function automatic logic [AW-1:0] smooth(
        input logic [AW-1:0] avg,
        input logic [WW-1:0] w,
        input logic [WW:0]   c,
        input logic [DW-1:0] d
    );
        logic [AW+WW-1:0] p_old;
        logic [DW+WW:0]   p_new;
        p_old = avg * w;
        p_new = d * c;
        smooth = p_old[AW+WW-1:FW] + AW'(p_new);
    endfunction

    function automatic logic in_zone(input logic [DW-1:0] r, input drd_pkg::cfg_t c);
        in_zone = (r >= c.zone_low) && (r <= c.zone_high);
    endfunction

    assign adv       = !out_valid_reg || out_ready;
    assign q_pop     = adv && !q_empty;
    assign keep_c    = (WW+1)'(1 << WW) - {1'b0, cfg.smooth_weight};
    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

    always_comb
    begin
        avg_a_next = avg_a_reg;
        avg_b_next = avg_b_reg;
        if (q_pop)
        begin
            avg_a_next = smooth(avg_a_reg, cfg.smooth_weight, keep_c, q_item.d_a);
            avg_b_next = smooth(avg_b_reg, cfg.smooth_weight, keep_c, q_item.d_b);
        end
    end

    always_comb
    begin
        seen = {in_zone(s1_rb_reg, cfg), in_zone(s1_ra_reg, cfg)};
        ev = drd_pkg::EV_NONE;
        prior_next = prior_reg;
        for (int i = 0; i < 4; i++)
            hist_next[i] = hist_reg[i];
        if (adv && s1_valid_reg)
        begin
            prior_next = seen;
            if (seen != prior_reg)
            begin
                hist_next[0] = hist_reg[1];
                hist_next[1] = hist_reg[2];
                hist_next[2] = hist_reg[3];
                hist_next[3] = seen;
                if (hist_next[0] == drd_pkg::SEEN_A && hist_next[1] == drd_pkg::SEEN_BOTH &&
                    hist_next[2] == drd_pkg::SEEN_B && hist_next[3] == drd_pkg::SEEN_NONE)
                    ev = drd_pkg::EV_OUT;
                else if (hist_next[0] == drd_pkg::SEEN_B &&
                         hist_next[1] == drd_pkg::SEEN_BOTH &&
                         hist_next[2] == drd_pkg::SEEN_A &&
                         hist_next[3] == drd_pkg::SEEN_NONE)
                    ev = drd_pkg::EV_IN;
                else if (hist_next[1] == drd_pkg::SEEN_B &&
                         hist_next[2] == drd_pkg::SEEN_BOTH &&
                         hist_next[3] == drd_pkg::SEEN_NONE)
                    ev = drd_pkg::EV_IN;
                else if (hist_next[1] == drd_pkg::SEEN_A &&
                         hist_next[2] == drd_pkg::SEEN_BOTH &&
                         hist_next[3] == drd_pkg::SEEN_NONE)
                    ev = drd_pkg::EV_OUT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_a_reg     <= '0;
            avg_b_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prior_reg     <= drd_pkg::SEEN_NONE;
            for (int i = 0; i < 4; i++)
                hist_reg[i] <= drd_pkg::SEEN_NONE;
        end
        else
        begin
            avg_a_reg <= avg_a_next;
            avg_b_reg <= avg_b_next;
            prior_reg <= prior_next;
            for (int i = 0; i < 4; i++)
                hist_reg[i] <= hist_next[i];
            if (adv)
            begin
                s1_valid_reg  <= !q_empty;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_ra_reg <= avg_a_next[AW-1:FW];
            s1_rb_reg <= avg_b_next[AW-1:FW];
        end
        if (adv && s1_valid_reg)
        begin
            out_reg.range_a    <= s1_ra_reg;
            out_reg.range_b    <= s1_rb_reg;
            out_reg.zone_seen  <= seen;
            out_reg.pass_event <= ev;
        end
    end

endmodule

### src/dual_range_direction_detector.sv
// Top level of the dual range direction detector: config registers, front
// end, queue and back end. Depends on drd_pkg, drd_intf and assert_macros.svh.
//
// Takes one sensor beat per clock while the queue is not full and delivers one
// result beat per clock while the result side is ready; an accepted beat passes
// the queue, the smoothing stage and the output register before result valid
// rises. The rate is set by the smoothing multiply-add in the back end, whose
// average feeds back into itself.
// The front end keeps accepting while results wait, until the QUEUE_DEPTH
// entry queue and the two back-end stages are full. Config writes are taken
// every cycle; indexes past the register list are ignored.
`include "assert_macros.svh"

module dual_range_direction_detector #(
    parameter int GLITCH_LIMIT = 10,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    drd_in_if.sink           sensor,
    drd_out_if.source        result,
    drd_cfg_if.sink          cfg
);

    drd_pkg::cfg_t       cfg_reg, cfg_next;
    drd_pkg::item_t      f_item, q_item;
    drd_pkg::q_status_t  q_status;
    logic                accept, q_pop;

    assign cfg.ready    = 1'b1;
    assign sensor.ready = !q_status.full;
    assign accept       = sensor.valid && sensor.ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.idx)
                drd_pkg::CFG_ZONE_LOW:  cfg_next.zone_low      = cfg.wdata[drd_pkg::DIST_W-1:0];
                drd_pkg::CFG_ZONE_HIGH: cfg_next.zone_high     = cfg.wdata[drd_pkg::DIST_W-1:0];
                drd_pkg::CFG_WEIGHT:    cfg_next.smooth_weight = cfg.wdata;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zone_low      <= '0;
            cfg_reg.zone_high     <= '1;
            cfg_reg.smooth_weight <= '0;
        end
        else
            cfg_reg <= cfg_next;
    end

    drd_front #(
        .GLITCH_LIMIT (GLITCH_LIMIT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .beat   (sensor.data),
        .item   (f_item)
    );

    drd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept),
        .wr_item (f_item),
        .pop     (q_pop),
        .rd_item (q_item),
        .status  (q_status)
    );

    drd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_status.empty),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_beat  (result.data)
    );

    `DRD_ASSERT(a_q_state, clk, rst_n, !(q_status.full && q_status.empty), "queue full and empty")
    `DRD_ASSERT_IMP(a_ev_code, clk, rst_n, result.valid,
        result.data.pass_event <= drd_pkg::EV_OUT, "bad event code")
    `DRD_ASSERT_IMP(a_ev_seen, clk, rst_n,
        result.valid && result.data.pass_event != drd_pkg::EV_NONE,
        result.data.zone_seen == drd_pkg::SEEN_NONE, "event while a sensor sees")

endmodule

### tb/range_check_pkg.sv
// Scoreboard for the dual range direction detector testbench.
// Predicts every result beat from accepted sensor beats and register writes.
// Depends on drd_pkg.
package range_check_pkg;
    import drd_pkg::*;

    localparam int GLITCH_LIMIT = 10;
    localparam logic [CODE_W-1:0] RC_RESERVED = 2'd3;
    localparam logic [IDX_W-1:0]  CFG_SPARE   = 2'd3;

    class passage_scoreboard;
        logic [DIST_W-1:0] zone_low;
        logic [DIST_W-1:0] zone_high;
        logic [WGT_W-1:0]  weight;
        logic [DIST_W-1:0] ghist [2][2];
        logic [AVG_W-1:0]  avg [2];
        logic [SEEN_W-1:0] prior_seen;
        logic [SEEN_W-1:0] seen_hist [4];
        out_beat_t         expected_q [$];
        int                mismatches;
        int                checked;
        int                in_events;
        int                out_events;

        function new();
            zone_low   = '0;
            zone_high  = '1;
            weight     = '0;
            prior_seen = SEEN_NONE;
            for (int s = 0; s < 2; s++)
            begin
                ghist[s][0] = '0;
                ghist[s][1] = '0;
                avg[s]      = '0;
            end
            foreach (seen_hist[i])
                seen_hist[i] = SEEN_NONE;
            mismatches = 0;
            checked    = 0;
            in_events  = 0;
            out_events = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [WGT_W-1:0] wdata);
            case (idx)
                CFG_ZONE_LOW:  zone_low  = wdata[DIST_W-1:0];
                CFG_ZONE_HIGH: zone_high = wdata[DIST_W-1:0];
                CFG_WEIGHT:    weight    = wdata;
                default: ;
            endcase
        endfunction

        // returns the sample two beats back; a lone spike in the middle is flattened
        function logic [DIST_W-1:0] filter_sample(int s, logic [DIST_W-1:0] smp);
            logic [DIST_W-1:0] mid;
            logic [DIST_W-1:0] old;
            int d_new;
            int d_mid;
            mid   = ghist[s][0];
            old   = ghist[s][1];
            d_new = int'(old) - int'(smp);
            d_mid = int'(mid) - int'(old);
            if (d_new < 0)
                d_new = -d_new;
            if (d_mid < 0)
                d_mid = -d_mid;
            if (d_new < GLITCH_LIMIT && d_mid > GLITCH_LIMIT)
                mid = old;
            ghist[s][1] = mid;
            ghist[s][0] = smp;
            return old;
        endfunction

        function logic [DIST_W-1:0] sensor_range(int s, logic [DIST_W-1:0] raw_dist,
                                                 logic [CODE_W-1:0] code);
            logic [DIST_W-1:0] d;
            logic [63:0]       acc;
            case (code)
                RC_VALID: d = filter_sample(s, raw_dist);
                RC_WEAK:  d = WEAK_VALUE;
                default:  d = ERROR_VALUE;
            endcase
            acc = 64'(avg[s]) * 64'(weight)
                + (64'(d) << FRAC_W) * (64'd65536 - 64'(weight));
            avg[s] = acc[FRAC_W +: AVG_W];
            return avg[s][AVG_W-1 -: DIST_W];
        endfunction

        function void note_beat(in_beat_t b);
            out_beat_t exp;
            exp.range_a    = sensor_range(0, b.raw_dist_a, b.read_code_a);
            exp.range_b    = sensor_range(1, b.raw_dist_b, b.read_code_b);
            exp.zone_seen  = {exp.range_b >= zone_low && exp.range_b <= zone_high,
                              exp.range_a >= zone_low && exp.range_a <= zone_high};
            exp.pass_event = EV_NONE;
            if (exp.zone_seen != prior_seen)
            begin
                seen_hist[0] = seen_hist[1];
                seen_hist[1] = seen_hist[2];
                seen_hist[2] = seen_hist[3];
                seen_hist[3] = exp.zone_seen;
                if (seen_hist[0] == SEEN_A && seen_hist[1] == SEEN_BOTH &&
                    seen_hist[2] == SEEN_B && seen_hist[3] == SEEN_NONE)
                    exp.pass_event = EV_OUT;
                else if (seen_hist[0] == SEEN_B && seen_hist[1] == SEEN_BOTH &&
                         seen_hist[2] == SEEN_A && seen_hist[3] == SEEN_NONE)
                    exp.pass_event = EV_IN;
                else if (seen_hist[1] == SEEN_B && seen_hist[2] == SEEN_BOTH &&
                         seen_hist[3] == SEEN_NONE)
                    exp.pass_event = EV_IN;
                else if (seen_hist[1] == SEEN_A && seen_hist[2] == SEEN_BOTH &&
                         seen_hist[3] == SEEN_NONE)
                    exp.pass_event = EV_OUT;
            end
            prior_seen = exp.zone_seen;
            expected_q.push_back(exp);
        endfunction

        function void check_beat(out_beat_t got);
            out_beat_t exp;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with nothing expected: a=%0d b=%0d seen=%0d ev=%0d",
                             got.range_a, got.range_b, got.zone_seen, got.pass_event);
                return;
            end
            exp = expected_q.pop_front();
            checked++;
            if (got.range_a !== exp.range_a || got.range_b !== exp.range_b ||
                got.zone_seen !== exp.zone_seen || got.pass_event !== exp.pass_event)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch at result %0d: expected a=%0d b=%0d seen=%0d ev=%0d,",
                              " got a=%0d b=%0d seen=%0d ev=%0d"},
                             checked, exp.range_a, exp.range_b, exp.zone_seen,
                             exp.pass_event, got.range_a, got.range_b, got.zone_seen,
                             got.pass_event);
            end
            else if (got.pass_event == EV_IN)
                in_events++;
            else if (got.pass_event == EV_OUT)
                out_events++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

### tb/testbench.sv
// Top of the dual range direction detector testbench: clock, reset, drivers,
// monitors and stimulus for directed and randomized passages.
// Depends on drd_pkg, drd_intf, range_check_pkg and the block's RTL.
module testbench;
    import drd_pkg::*;
    import range_check_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int PHASES = 10;
    localparam int PHASE_BEATS = 130;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    drd_in_if  sensor_ch ();
    drd_out_if result_ch ();
    drd_cfg_if cfg_ch ();

    dual_range_direction_detector dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sensor (sensor_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    passage_scoreboard sb;
    int beats_sent = 0;
    int reg_writes = 0;
    int settings = 0;
    int passages = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;
    int zlo = 0;
    int zhi = 4095;
    int idle_cycles = 0;
    int stall_tick = 0;

    always #6 clk = ~clk;

    initial
    begin
        sensor_ch.valid = 1'b0;
        sensor_ch.data  = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.idx      = '0;
        cfg_ch.wdata    = '0;
        result_ch.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        stall_tick++;
        case ((stall_tick / 250) % 4)
            0: result_ch.ready <= 1'b1;
            1: result_ch.ready <= ($urandom_range(0, 9) < 7);
            2: result_ch.ready <= ((stall_tick % 9) < 5);
            default: result_ch.ready <= ($urandom_range(0, 9) < 2);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                sb.check_beat(result_ch.data);
            if (sensor_ch.valid && sensor_ch.ready)
                sb.note_beat(sensor_ch.data);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.idx, cfg_ch.wdata);
            if ((result_ch.valid && result_ch.ready) || (sensor_ch.valid && sensor_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results pending",
                         idle_cycles, sb.pending());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic in_beat_t mk_beat(logic [DIST_W-1:0] da, logic [CODE_W-1:0] ca,
                                         logic [DIST_W-1:0] db, logic [CODE_W-1:0] cb);
        in_beat_t b;
        b.raw_dist_a  = da;
        b.read_code_a = ca;
        b.raw_dist_b  = db;
        b.read_code_b = cb;
        return b;
    endfunction

    task automatic send_beat(in_beat_t b);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                sensor_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        if (burst_left > 0)
            burst_left--;
        sensor_ch.valid <= 1'b1;
        sensor_ch.data  <= b;
        @(posedge clk);
        while (!sensor_ch.ready)
            @(posedge clk);
        beats_sent++;
    endtask

    // leaves valid high; the caller drops it after the last write
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [WGT_W-1:0] wdata);
        cfg_ch.valid <= 1'b1;
        cfg_ch.idx   <= idx;
        cfg_ch.wdata <= wdata;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        reg_writes++;
    endtask

    task automatic drain();
        sensor_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic apply_setting(int lo, int hi, logic [WGT_W-1:0] w);
        zlo = lo;
        zhi = hi;
        write_reg(CFG_ZONE_LOW, {4'($urandom), DIST_W'(lo)});
        write_reg(CFG_ZONE_HIGH, {4'($urandom), DIST_W'(hi)});
        write_reg(CFG_WEIGHT, w);
        cfg_ch.valid <= 1'b0;
        settings++;
    endtask

    // picks a reading inside or outside the current zone, but one draw in sixteen stays random
    task automatic make_reading(input bit want_in, output logic [DIST_W-1:0] rd_dist,
                                output logic [CODE_W-1:0] code);
        code = RC_VALID;
        rd_dist = DIST_W'($urandom);
        if ($urandom_range(0, 15) == 0)
            return;
        if (want_in)
        begin
            if (zlo <= zhi)
            begin
                if (zlo <= int'(WEAK_VALUE) && zhi >= int'(WEAK_VALUE)
                    && $urandom_range(0, 4) == 0)
                    code = RC_WEAK;
                else
                    rd_dist = DIST_W'($urandom_range(zhi, zlo));
            end
        end
        else if ((zlo > int'(ERROR_VALUE) || zhi < int'(ERROR_VALUE))
                 && $urandom_range(0, 5) == 0)
            code = ($urandom_range(0, 1) == 0) ? RC_ERROR : RC_RESERVED;
        else if (zlo > 0 && (zhi == 4095 || $urandom_range(0, 1) == 0))
            rd_dist = DIST_W'($urandom_range(zlo - 1, 0));
        else if (zhi < 4095)
            rd_dist = DIST_W'($urandom_range(4095, zhi + 1));
    endtask

    task automatic send_seen(logic [SEEN_W-1:0] st);
        logic [DIST_W-1:0] da;
        logic [DIST_W-1:0] db;
        logic [CODE_W-1:0] ca;
        logic [CODE_W-1:0] cb;
        make_reading(st[0], da, ca);
        make_reading(st[1], db, cb);
        send_beat(mk_beat(da, ca, db, cb));
    endtask

    task automatic run_passage(bit inward);
        logic [SEEN_W-1:0] steps [4];
        if (inward)
            steps = '{SEEN_B, SEEN_BOTH, SEEN_A, SEEN_NONE};
        else
            steps = '{SEEN_A, SEEN_BOTH, SEEN_B, SEEN_NONE};
        repeat ($urandom_range(1, 3)) send_seen(SEEN_NONE);
        foreach (steps[i])
            repeat ($urandom_range(2, 6)) send_seen(steps[i]);
        passages++;
    endtask

    task automatic run_phase(int p);
        int lo;
        int hi;
        int start;
        logic [WGT_W-1:0] w;
        case (p)
            0:
            begin
                lo = 0;
                hi = 4095;
            end
            1:
            begin
                lo = 4095;
                hi = 0;
            end
            2:
            begin
                lo = 0;
                hi = 0;
            end
            3:
            begin
                lo = 4095;
                hi = 4095;
            end
            default:
            begin
                lo = $urandom_range(0, 3500);
                hi = lo + $urandom_range(20, 600);
                if (hi > 4095)
                    hi = 4095;
                if ($urandom_range(0, 9) == 0)
                    hi = $urandom_range(0, lo);
            end
        endcase
        case (p % 5)
            0: w = '0;
            1: w = '1;
            2: w = WGT_W'($urandom_range(1, 4000));
            3: w = WGT_W'($urandom_range(20000, 45000));
            default: w = WGT_W'($urandom);
        endcase
        apply_setting(lo, hi, w);
        gaps_on = (p % 3 != 2);
        start = beats_sent;
        while (beats_sent - start < PHASE_BEATS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: run_passage($urandom_range(0, 1));
                6, 7: repeat (4) repeat ($urandom_range(1, 4)) send_seen(SEEN_W'($urandom));
                default:
                    repeat ($urandom_range(1, 5))
                        send_beat(mk_beat(DIST_W'($urandom), CODE_W'($urandom),
                                          DIST_W'($urandom), CODE_W'($urandom)));
            endcase
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zone 1200..1300 puts weak readings inside and error readings outside
        write_reg(CFG_SPARE, 16'hFFFF);
        apply_setting(1200, 1300, '0);
        gaps_on = 1'b0;
        send_beat(mk_beat(12'd4095, RC_VALID, 12'd0, RC_VALID));
        send_beat(mk_beat(12'd0, RC_VALID, 12'd4095, RC_VALID));
        send_beat(mk_beat(12'd500, RC_VALID, 12'd2000, RC_VALID));
        send_beat(mk_beat(12'd900, RC_VALID, 12'd1250, RC_VALID));
        send_beat(mk_beat(12'd505, RC_VALID, 12'd1995, RC_VALID));
        send_beat(mk_beat(12'd1250, RC_VALID, 12'd1250, RC_VALID));
        send_beat(mk_beat(12'd1251, RC_VALID, 12'd1249, RC_VALID));
        send_beat(mk_beat(12'd4095, RC_ERROR, 12'd4095, RC_ERROR));
        send_beat(mk_beat(12'd0, RC_WEAK, 12'd0, RC_ERROR));
        send_beat(mk_beat(12'd4095, RC_WEAK, 12'd4095, RC_WEAK));
        send_beat(mk_beat(12'd0, RC_ERROR, 12'd0, RC_WEAK));
        send_beat(mk_beat(12'd4095, RC_ERROR, 12'd4095, RC_ERROR));
        send_beat(mk_beat(12'd0, RC_ERROR, 12'd0, RC_WEAK));
        send_beat(mk_beat(12'd0, RC_WEAK, 12'd0, RC_WEAK));
        send_beat(mk_beat(12'd0, RC_WEAK, 12'd0, RC_ERROR));
        send_beat(mk_beat(12'd0, RC_ERROR, 12'd0, RC_ERROR));
        send_beat(mk_beat(12'd0, RC_ERROR, 12'd0, RC_WEAK));
        send_beat(mk_beat(12'd0, RC_WEAK, 12'd0, RC_WEAK));
        send_beat(mk_beat(12'd0, RC_ERROR, 12'd0, RC_ERROR));
        send_beat(mk_beat(12'd0, RC_WEAK, 12'd0, RC_ERROR));
        send_beat(mk_beat(12'd0, RC_WEAK, 12'd0, RC_WEAK));
        send_beat(mk_beat(12'd0, RC_ERROR, 12'd0, RC_ERROR));
        send_beat(mk_beat(12'd4095, RC_RESERVED, 12'd4095, RC_RESERVED));
        drain();

        for (int p = 0; p < PHASES; p++)
            run_phase(p);

        $display("covered %0d sensor beats under %0d register settings (%0d writes), %0d passages",
                 beats_sent, settings, reg_writes, passages);
        $display("checked %0d results: %0d inward and %0d outward events, %0d mismatches",
                 sb.checked, sb.in_events, sb.out_events, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
